// ===== src/sfsd_pkg.sv =====
`timescale 1ns / 1ps

package sfsd_pkg;

    localparam int SyncBytes   = 4;
    localparam int MaxChannels = 16;
    localparam int CmdDepth    = 2;

    localparam int SyncIdxW = 3;
    localparam int LenW     = 7;
    localparam int FmtW     = 3;
    localparam int ChCntW   = 5;
    localparam int ChW      = 4;
    localparam int RowW     = 6;
    localparam int SampleW  = 64;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    localparam logic [7:0] CrcInit = 8'hFF;
    localparam logic [7:0] CrcPoly = 8'h31;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SYNC_PATTERN   = 3'd0,
        REG_SYNC_LENGTH    = 3'd1,
        REG_PAYLOAD_LENGTH = 3'd2,
        REG_SAMPLE_FORMAT  = 3'd3,
        REG_CHANNEL_COUNT  = 3'd4,
        REG_CHECK_MODE     = 3'd5,
        REG_DISCARD_FRAMES = 3'd6
    } reg_idx_t;

    localparam logic [FmtW-1:0] FMT_U8  = 3'd0;
    localparam logic [FmtW-1:0] FMT_I8  = 3'd1;
    localparam logic [FmtW-1:0] FMT_U16 = 3'd2;
    localparam logic [FmtW-1:0] FMT_I16 = 3'd3;
    localparam logic [FmtW-1:0] FMT_U32 = 3'd4;
    localparam logic [FmtW-1:0] FMT_I32 = 3'd5;
    localparam logic [FmtW-1:0] FMT_F32 = 3'd6;
    localparam logic [FmtW-1:0] FMT_F64 = 3'd7;

    localparam logic [1:0] CHECK_NONE = 2'd0;
    localparam logic [1:0] CHECK_SUM  = 2'd1;
    localparam logic [1:0] CHECK_CRC  = 2'd2;
    localparam logic [1:0] CHECK_BAD  = 2'd3;

    typedef struct packed {
        logic [31:0]       sync_pattern;
        logic [SyncIdxW-1:0] sync_length;
        logic [LenW-1:0]   payload_length;
        logic [FmtW-1:0]   sample_format;
        logic [ChCntW-1:0] channel_count;
        logic [1:0]        check_mode;
        logic              discard_frames;
    } cfg_t;

    localparam cfg_t CfgReset = '{
        sync_pattern:   32'd8995,
        sync_length:    3'd2,
        payload_length: 7'd20,
        sample_format:  FMT_F32,
        channel_count:  5'd5,
        check_mode:     CHECK_NONE,
        discard_frames: 1'b0
    };

    typedef struct packed {
        logic is_error;
    } cmd_t;

    // log2 of the sample size in bytes
    function automatic logic [1:0] size_lg(input logic [FmtW-1:0] fmt);
        logic [1:0] lg;
        unique case (fmt)
            FMT_U8, FMT_I8:            lg = 2'd0;
            FMT_U16, FMT_I16:          lg = 2'd1;
            FMT_U32, FMT_I32, FMT_F32: lg = 2'd2;
            default:                   lg = 2'd3;
        endcase
        return lg;
    endfunction

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== src/sfsd_ram.sv =====
`timescale 1ns / 1ps

module sfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/sfsd_cmdq.sv =====
`timescale 1ns / 1ps

module sfsd_cmdq #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfsd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output sfsd_pkg::cmd_t pop_cmd,
    output logic           empty
);

    import sfsd_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    cmd_t            entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/sfsd_front.sv =====
`timescale 1ns / 1ps

module sfsd_front #(
    parameter int FRAME_BYTES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfsd_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [sfsd_pkg::CfgDataW-1:0]   cfg_data,
    output sfsd_pkg::cfg_t                  cfg,
    output logic                            mem_we,
    output logic [$clog2(FRAME_BYTES)-1:0]  mem_waddr,
    output logic [7:0]                      mem_wdata,
    output logic                            q_push,
    output sfsd_pkg::cmd_t                  q_cmd,
    input  logic                            q_full,
    input  logic                            frame_done
);

    import sfsd_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    typedef enum logic [2:0] {
        VC_LOAD = 3'b001,
        VC_RUN  = 3'b010,
        VC_DONE = 3'b100
    } vc_state_t;

    cfg_t                cfg_reg, cfg_next;
    logic                cfg_known;
    logic                restart;

    vc_state_t           vc_state_reg, vc_state_next;
    logic [LenW-1:0]     rem_reg, rem_next;
    logic                ok_reg, ok_next;
    logic [7:0]          group;
    logic                static_ok;
    logic                settings_ok;

    logic [SyncIdxW-1:0] sync_idx_reg, sync_idx_next;
    logic                in_payload_reg, in_payload_next;
    logic [LenW-1:0]     cnt_reg, cnt_next;
    logic [7:0]          sum_reg, sum_next;
    logic [7:0]          crc_reg, crc_next;
    logic                pend_reg, pend_next;

    logic                accept, work;
    logic [7:0]          sync_byte;
    logic [SyncIdxW-1:0] hit_idx;
    logic                collect, frame_end, passed;

    assign cfg       = cfg_reg;
    assign cfg_ready = 1'b1;

    // register file
    always_comb
    begin
        cfg_next  = cfg_reg;
        cfg_known = 1'b1;
        unique case (cfg_index)
            REG_SYNC_PATTERN:   cfg_next.sync_pattern   = cfg_data;
            REG_SYNC_LENGTH:    cfg_next.sync_length    = cfg_data[SyncIdxW-1:0];
            REG_PAYLOAD_LENGTH: cfg_next.payload_length = cfg_data[LenW-1:0];
            REG_SAMPLE_FORMAT:  cfg_next.sample_format  = cfg_data[FmtW-1:0];
            REG_CHANNEL_COUNT:  cfg_next.channel_count  = cfg_data[ChCntW-1:0];
            REG_CHECK_MODE:     cfg_next.check_mode     = cfg_data[1:0];
            REG_DISCARD_FRAMES: cfg_next.discard_frames = cfg_data[0];
            default:            cfg_known = 1'b0;
        endcase
    end

    assign restart = cfg_valid && cfg_ready && cfg_known;

    // settings check; the payload divisibility test subtracts one group a cycle
    assign group = 8'(cfg_reg.channel_count) << size_lg(cfg_reg.sample_format);

    assign static_ok = (cfg_reg.sync_length != '0)
                    && (cfg_reg.sync_length <= SyncIdxW'(4))
                    && (32'(cfg_reg.sync_length) <= SyncBytes)
                    && (cfg_reg.payload_length != '0)
                    && (32'(cfg_reg.payload_length) <= FRAME_BYTES)
                    && (cfg_reg.channel_count != '0)
                    && (32'(cfg_reg.channel_count) <= MaxChannels)
                    && (cfg_reg.check_mode != CHECK_BAD);

    always_comb
    begin
        vc_state_next = vc_state_reg;
        rem_next      = rem_reg;
        ok_next       = ok_reg;
        unique case (vc_state_reg)
            VC_LOAD:
            begin
                rem_next      = cfg_reg.payload_length;
                ok_next       = 1'b0;
                vc_state_next = VC_RUN;
            end
            VC_RUN:
            begin
                if ((group == '0) || ({1'b0, rem_reg} < group))
                begin
                    ok_next       = (rem_reg == '0) && (group != '0);
                    vc_state_next = VC_DONE;
                end
                else
                begin
                    rem_next = rem_reg - group[LenW-1:0];
                end
            end
            VC_DONE:
            begin
                vc_state_next = VC_DONE;
            end
            default:
            begin
                vc_state_next = VC_LOAD;
            end
        endcase
        if (restart)
        begin
            vc_state_next = VC_LOAD;
            ok_next       = 1'b0;
        end
    end

    assign settings_ok = (vc_state_reg == VC_DONE) && ok_reg && static_ok;

    assign in_stall = (vc_state_reg != VC_DONE) || (in_payload_reg && (pend_reg || q_full));
    assign accept   = in_valid && !in_stall;
    assign work     = accept && settings_ok;

    assign sync_byte = cfg_reg.sync_pattern[8*sync_idx_reg[1:0] +: 8];
    assign collect   = (cnt_reg < cfg_reg.payload_length);

    assign mem_waddr = cnt_reg[AW-1:0];
    assign mem_wdata = rx_byte;

    always_comb
    begin
        sync_idx_next   = sync_idx_reg;
        in_payload_next = in_payload_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        crc_next        = crc_reg;
        pend_next       = pend_reg;
        mem_we          = 1'b0;
        q_push          = 1'b0;
        q_cmd           = '0;
        hit_idx         = '0;
        frame_end       = 1'b0;
        passed          = 1'b1;

        if (frame_done)
        begin
            pend_next = 1'b0;
        end

        if (restart)
        begin
            sync_idx_next   = '0;
            in_payload_next = 1'b0;
            cnt_next        = '0;
            sum_next        = '0;
            crc_next        = CrcInit;
        end
        else if (work)
        begin
            if (!in_payload_reg)
            begin
                if (rx_byte == sync_byte)
                begin
                    hit_idx = sync_idx_reg + SyncIdxW'(1);
                end
                else if (rx_byte == cfg_reg.sync_pattern[7:0])
                begin
                    hit_idx = SyncIdxW'(1);
                end
                else
                begin
                    hit_idx = '0;
                end
                if (hit_idx >= cfg_reg.sync_length)
                begin
                    sync_idx_next   = '0;
                    in_payload_next = 1'b1;
                    cnt_next        = '0;
                    sum_next        = '0;
                    crc_next        = CrcInit;
                end
                else
                begin
                    sync_idx_next = hit_idx;
                end
            end
            else
            begin
                if (collect)
                begin
                    mem_we    = 1'b1;
                    sum_next  = sum_reg + rx_byte;
                    crc_next  = crc8_update(crc_reg, rx_byte);
                    cnt_next  = cnt_reg + LenW'(1);
                    frame_end = (cnt_next == cfg_reg.payload_length)
                             && (cfg_reg.check_mode == CHECK_NONE);
                end
                else
                begin
                    frame_end = 1'b1;
                    passed    = (cfg_reg.check_mode == CHECK_SUM) ? (rx_byte == sum_reg)
                                                                  : (rx_byte == crc_reg);
                end
                if (frame_end)
                begin
                    if (!cfg_reg.discard_frames)
                    begin
                        q_push         = 1'b1;
                        q_cmd.is_error = !passed;
                        if (passed)
                        begin
                            pend_next = 1'b1;
                        end
                    end
                    sync_idx_next   = '0;
                    in_payload_next = 1'b0;
                    cnt_next        = '0;
                    sum_next        = '0;
                    crc_next        = CrcInit;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= CfgReset;
            vc_state_reg   <= VC_LOAD;
            rem_reg        <= '0;
            ok_reg         <= 1'b0;
            sync_idx_reg   <= '0;
            in_payload_reg <= 1'b0;
            cnt_reg        <= '0;
            sum_reg        <= '0;
            crc_reg        <= CrcInit;
            pend_reg       <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                cfg_reg <= cfg_next;
            end
            vc_state_reg   <= vc_state_next;
            rem_reg        <= rem_next;
            ok_reg         <= ok_next;
            sync_idx_reg   <= sync_idx_next;
            in_payload_reg <= in_payload_next;
            cnt_reg        <= cnt_next;
            sum_reg        <= sum_next;
            crc_reg        <= crc_next;
            pend_reg       <= pend_next;
        end
    end

endmodule

// ===== src/sfsd_back.sv =====
`timescale 1ns / 1ps

module sfsd_back #(
    parameter int FRAME_BYTES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sfsd_pkg::cfg_t                  cfg,
    input  logic                            q_empty,
    input  sfsd_pkg::cmd_t                  q_cmd,
    output logic                            q_pop,
    output logic [$clog2(FRAME_BYTES)-1:0]  mem_raddr,
    input  logic [7:0]                      mem_rdata,
    output logic                            frame_done,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sfsd_pkg::SampleW-1:0]    sample_bits,
    output logic [sfsd_pkg::ChW-1:0]        channel,
    output logic [sfsd_pkg::RowW-1:0]       row,
    output logic                            status,
    output logic                            last
);

    import sfsd_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_READ = 4'b0010,
        B_WAIT = 4'b0100,
        B_OUT  = 4'b1000
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [LenW-1:0]    addr_reg, addr_next;
    logic [2:0]         lane_reg, lane_next;
    logic [ChW-1:0]     ch_reg, ch_next;
    logic [RowW-1:0]    row_reg, row_next;
    logic [SampleW-1:0] acc_reg, acc_next;
    logic               status_reg, status_next;
    logic               last_reg, last_next;

    logic [SampleW-1:0] assembled;
    logic [2:0]         lanes_m1;
    logic [LenW-1:0]    addr_inc;

    function automatic logic [SampleW-1:0] extend(input logic [FmtW-1:0] fmt,
                                                  input logic [SampleW-1:0] a);
        logic [SampleW-1:0] v;
        unique case (fmt)
            FMT_I8:  v = {{56{a[7]}}, a[7:0]};
            FMT_I16: v = {{48{a[15]}}, a[15:0]};
            FMT_I32: v = {{32{a[31]}}, a[31:0]};
            default: v = a;
        endcase
        return v;
    endfunction

    assign lanes_m1    = 3'((4'd1 << size_lg(cfg.sample_format)) - 4'd1);
    assign addr_inc    = addr_reg + LenW'(1);
    assign mem_raddr   = addr_reg[AW-1:0];

    assign out_valid   = (state_reg == B_OUT);
    assign sample_bits = acc_reg;
    assign channel     = ch_reg;
    assign row         = row_reg;
    assign status      = status_reg;
    assign last        = last_reg;

    always_comb
    begin
        assembled                  = acc_reg;
        assembled[8*lane_reg +: 8] = mem_rdata;
    end

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        lane_next   = lane_reg;
        ch_next     = ch_reg;
        row_next    = row_reg;
        acc_next    = acc_reg;
        status_next = status_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        frame_done  = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    ch_next  = '0;
                    row_next = '0;
                    acc_next = '0;
                    if (q_cmd.is_error)
                    begin
                        status_next = 1'b1;
                        last_next   = 1'b1;
                        state_next  = B_OUT;
                    end
                    else
                    begin
                        status_next = 1'b0;
                        last_next   = 1'b0;
                        addr_next   = '0;
                        lane_next   = '0;
                        state_next  = B_READ;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_WAIT;
            end
            B_WAIT:
            begin
                addr_next = addr_inc;
                if (lane_reg == lanes_m1)
                begin
                    acc_next   = extend(cfg.sample_format, assembled);
                    last_next  = (addr_inc == cfg.payload_length);
                    state_next = B_OUT;
                end
                else
                begin
                    acc_next   = assembled;
                    lane_next  = lane_reg + 3'd1;
                    state_next = B_READ;
                end
            end
            B_OUT:
            begin
                if (!out_stall)
                begin
                    if (last_reg)
                    begin
                        frame_done = !status_reg;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        lane_next = '0;
                        acc_next  = '0;
                        if ({1'b0, ch_reg} == cfg.channel_count - ChCntW'(1))
                        begin
                            ch_next  = '0;
                            row_next = row_reg + RowW'(1);
                        end
                        else
                        begin
                            ch_next = ch_reg + ChW'(1);
                        end
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        lane_reg   <= lane_next;
        ch_reg     <= ch_next;
        row_reg    <= row_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

endmodule

// ===== src/sync_frame_sample_deframer.sv =====
`timescale 1ns / 1ps
// Bytes are taken one per cycle while hunting sync and collecting payload; payload bytes
// stall while the previous frame's samples are still being read out of the frame store or
// while the command queue is full. Each sample is read byte by byte from the frame store
// (one read port, one byte a read) and offered once complete, and the next is read only after
// it is taken; a failed check gives a single error result. Async active-low reset; after reset
// and after each write to a known register, input stalls while the settings are checked.
module sync_frame_sample_deframer #(
    parameter int FRAME_BYTES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sfsd_pkg::SampleW-1:0]  sample_bits,
    output logic [sfsd_pkg::ChW-1:0]      channel,
    output logic [sfsd_pkg::RowW-1:0]     row,
    output logic                          status,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfsd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [sfsd_pkg::CfgDataW-1:0] cfg_data
);

    import sfsd_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    cfg_t            cfg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]      mem_wdata, mem_rdata;
    logic            q_push, q_full, q_pop, q_empty;
    cmd_t            q_push_cmd, q_pop_cmd;
    logic            frame_done;

    sfsd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .q_push     (q_push),
        .q_cmd      (q_push_cmd),
        .q_full     (q_full),
        .frame_done (frame_done)
    );

    sfsd_cmdq #(
        .DEPTH (CmdDepth)
    ) u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .empty    (q_empty)
    );

    sfsd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sfsd_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_cmd       (q_pop_cmd),
        .q_pop       (q_pop),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .frame_done  (frame_done),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_bits (sample_bits),
        .channel     (channel),
        .row         (row),
        .status      (status),
        .last        (last)
    );

endmodule

// ===== src/sfsd_checker.sv =====
`timescale 1ns / 1ps

module sfsd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [sfsd_pkg::SampleW-1:0] sample_bits,
    input logic [sfsd_pkg::ChW-1:0]     channel,
    input logic [sfsd_pkg::RowW-1:0]    row,
    input logic                         status,
    input logic                         last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_bits) && $stable(channel)
            && $stable(row) && $stable(status) && $stable(last))
        else $error("stalled result changed");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && (sample_bits == '0) && (channel == '0) && (row == '0))
        else $error("malformed check-failure result");

    a_transfer_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("result offered straight after a transfer");

endmodule

bind sync_frame_sample_deframer sfsd_checker u_sfsd_checker (.*);
